[sv/dlb_pkg.sv]
// Shared types and constants for the dense layer with bias.
`default_nettype none
package dlb_pkg;

  localparam int DEF_MAX_INPUTS  = 64;
  localparam int DEF_MAX_OUTPUTS = 64;

  localparam int ACC_W     = 40;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'b1;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_ACT    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] data_value;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [31:0] out_value;
    logic               last_of_run;
  } out_word_t;

endpackage
`default_nettype wire

[sv/dlb_ram.sv]
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module dlb_ram #(
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/dlb_cell.sv]
// One accumulator cell of the rotating accumulator chain.
`default_nettype none
module dlb_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             shift,
  input  wire logic signed [dlb_pkg::ACC_W-1:0] din,
  output      logic signed [dlb_pkg::ACC_W-1:0] acc
);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (shift) begin
      acc <= din;
    end
  end

endmodule
`default_nettype wire

[sv/dense_layer_with_bias.sv]
// Top level of the dense layer with bias: control, shared MAC, stores and cell chain.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data   (dlb_pkg::in_word_t)
//   out       output     out_valid / out_ready out_data  (dlb_pkg::out_word_t)
//   cfg       input      cfg_write             cfg_index, cfg_data
//
// Weight, bias, kind 3 and out-of-range activation words are taken without leaving idle.
// An active activation makes one full rotation of the accumulator chain through
// the single multiply-accumulate at its head, behind the two-stage store read
// and multiply pipeline.
// The last active row adds a second rotation of MAX_OUTPUTS steps that emits
// results; each step with a result waits while the full output register is not taken.
// Reset is synchronous, clears all accumulators and sets both counts to 64.
`default_nettype none
module dense_layer_with_bias #(
  parameter int MAX_INPUTS  = dlb_pkg::DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = dlb_pkg::DEF_MAX_OUTPUTS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire dlb_pkg::in_word_t                   in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      dlb_pkg::out_word_t                  out_data,
  input  wire logic                                cfg_write,
  input  wire logic [dlb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dlb_pkg::CFG_W-1:0]           cfg_data
);

  localparam int ACC_W     = dlb_pkg::ACC_W;
  localparam int ROW_LIMIT = (MAX_INPUTS < 64) ? MAX_INPUTS : 64;
  localparam int RW        = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
  localparam int CW        = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CNT_W     = $clog2(MAX_OUTPUTS + 2);

  localparam logic [6:0] ROW_LIM7 = 7'(ROW_LIMIT);
  localparam logic [6:0] MAXO7    = 7'(MAX_OUTPUTS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_OUTPUTS + 1);
  localparam logic [CNT_W-1:0] CNT_ADD0  = CNT_W'(2);
  localparam logic [CW-1:0]    EMIT_LAST = CW'(MAX_OUTPUTS - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = 40'sh00_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = 40'shFF_8000_0000;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]              state;
  logic [6:0]              input_count;
  logic [6:0]              output_count;
  logic [6:0]              n_act;
  logic [6:0]              m_act;
  logic [6:0]              row7;
  logic [6:0]              col7;
  logic                    accept;
  logic                    w_we;
  logic                    b_we;
  logic                    start;
  logic [RW-1:0]           row_q;
  logic                    first_q;
  logic                    last_q;
  logic signed [15:0]      x_q;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        slot;
  logic [CW-1:0]           ecnt;
  logic [15:0]             w_rd;
  logic [15:0]             b_rd;
  logic signed [31:0]      prod;
  logic signed [15:0]      bias_q;
  logic signed [ACC_W-1:0] acc_q [MAX_OUTPUTS];
  logic signed [ACC_W-1:0] head_next;
  logic signed [ACC_W-1:0] base;
  logic                    add_stage;
  logic                    upd;
  logic                    emit_has;
  logic                    emit_step;
  logic                    emit_load;
  logic                    shift;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    if (input_count == 7'd0) begin
      n_act = 7'd1;
    end else if (input_count > ROW_LIM7) begin
      n_act = ROW_LIM7;
    end else begin
      n_act = input_count;
    end
    if (output_count == 7'd0) begin
      m_act = 7'd1;
    end else if (output_count > MAXO7) begin
      m_act = MAXO7;
    end else begin
      m_act = output_count;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign row7     = {1'b0, in_data.row_index};
  assign col7     = {1'b0, in_data.col_index};
  assign w_we     = accept && (in_data.kind == dlb_pkg::KIND_WEIGHT)
                    && (row7 < ROW_LIM7) && (col7 < MAXO7);
  assign b_we     = accept && (in_data.kind == dlb_pkg::KIND_BIAS) && (col7 < MAXO7);
  assign start    = accept && (in_data.kind == dlb_pkg::KIND_ACT) && (row7 < n_act);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= dlb_pkg::COUNT_RESET;
      output_count <= dlb_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dlb_pkg::REG_INPUT_COUNT: begin
          input_count <= cfg_data;
        end
        dlb_pkg::REG_OUTPUT_COUNT: begin
          output_count <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  dlb_ram #(
    .WIDTH(16),
    .AW   (RW + CW)
  ) u_weight_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr({in_data.row_index[RW-1:0], in_data.col_index[CW-1:0]}),
    .wdata(in_data.data_value),
    .raddr({row_q, cnt[CW-1:0]}),
    .rdata(w_rd)
  );

  dlb_ram #(
    .WIDTH(16),
    .AW   (CW)
  ) u_bias_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(in_data.col_index[CW-1:0]),
    .wdata(in_data.data_value),
    .raddr(cnt[CW-1:0]),
    .rdata(b_rd)
  );

  always_ff @(posedge clk) begin
    prod   <= 32'(x_q) * 32'($signed(w_rd));
    bias_q <= $signed(b_rd);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row_q   <= in_data.row_index[RW-1:0];
      x_q     <= in_data.data_value;
      first_q <= (in_data.row_index == 6'd0);
      last_q  <= (row7 == n_act - 7'd1);
    end
  end

  assign add_stage = (state == ST_ACC) && (cnt >= CNT_ADD0);
  assign slot      = cnt - CNT_ADD0;
  assign upd       = add_stage && (7'(slot) < m_act);
  assign emit_has  = (7'(ecnt) < m_act);
  assign emit_step = (state == ST_EMIT) && (!emit_has || !out_valid || out_ready);
  assign emit_load = emit_step && emit_has;
  assign shift     = add_stage || emit_step;

  always_comb begin
    base      = first_q ? ACC_W'({{12{bias_q[15]}}, bias_q, 12'b0}) : acc_q[0];
    head_next = acc_q[0];
    if (upd) begin
      head_next = base + ACC_W'(prod);
    end
  end

  for (genvar i = 0; i < MAX_OUTPUTS; i++) begin : g_cell
    logic signed [ACC_W-1:0] din;
    if (i == MAX_OUTPUTS - 1) begin : g_head
      assign din = head_next;
    end else begin : g_link
      assign din = acc_q[i+1];
    end
    dlb_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .din  (din),
      .acc  (acc_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt  <= '0;
          ecnt <= '0;
          if (start) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= last_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            ecnt <= ecnt + CW'(1);
            if (ecnt == EMIT_LAST) begin
              ecnt  <= '0;
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data.out_index   <= 6'(ecnt);
      out_data.out_value   <= sat32(acc_q[0]);
      out_data.last_of_run <= (7'(ecnt) == m_act - 7'd1);
    end
  end

endmodule
`default_nettype wire
